// ===== rtl/tqdd_pkg.sv =====
`default_nettype none

package tqdd_pkg;

    // Field widths
    localparam int TILE_W = 8;
    localparam int KEY_W  = 4 * TILE_W;
    localparam int IDX_W  = 8;
    localparam int ATTR_W = 2;
    localparam int MODE_W = 2;
    localparam int PACK_W = 4 * ATTR_W;

    // Item modes
    localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ENCODE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    // Lookup token handed from cell to cell
    typedef struct packed {
        logic              valid;
        logic              hit;
        logic              fresh;
        logic [IDX_W-1:0]  idx;
        logic [KEY_W-1:0]  key;
    } dict_token_t;

endpackage

`default_nettype wire

// ===== rtl/tqdd_if.sv =====
`default_nettype none

interface tqdd_in_if;
    logic                             valid;
    logic                             ready;
    logic [tqdd_pkg::MODE_W-1:0]      mode;
    logic [tqdd_pkg::TILE_W-1:0]      tile_nw;
    logic [tqdd_pkg::TILE_W-1:0]      tile_ne;
    logic [tqdd_pkg::TILE_W-1:0]      tile_sw;
    logic [tqdd_pkg::TILE_W-1:0]      tile_se;
    logic                             has_east;
    logic                             has_south;
    logic [tqdd_pkg::TILE_W-1:0]      attr_slot;
    logic [tqdd_pkg::ATTR_W-1:0]      attr_value;

    modport source (
        output valid, mode, tile_nw, tile_ne, tile_sw, tile_se,
               has_east, has_south, attr_slot, attr_value,
        input  ready
    );
    modport sink (
        input  valid, mode, tile_nw, tile_ne, tile_sw, tile_se,
               has_east, has_south, attr_slot, attr_value,
        output ready
    );
endinterface

interface tqdd_out_if;
    logic                             valid;
    logic                             ready;
    logic [tqdd_pkg::IDX_W-1:0]       group_index;
    logic                             is_new;
    logic [tqdd_pkg::PACK_W-1:0]      packed_attr;
    logic                             overflow;

    modport source (
        output valid, group_index, is_new, packed_attr, overflow,
        input  ready
    );
    modport sink (
        input  valid, group_index, is_new, packed_attr, overflow,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/tile_quad_dedup_dictionary_unit.sv =====
`default_nettype none

// Channel   Dir   Carries
// item      in    mode, four tile indices, edge flags, attribute slot and value
// result    out   group index, new flag, packed attributes, overflow flag
//
// An encode goes through the launch register, the DICT_DEPTH cells (the key walks
// the row one cell per cycle) and the result registers. Load, clear and unused
// modes skip the row. One item is worked on at a time; the next is taken once
// the previous result sits in the output register, even if that is not yet taken.
// Reset empties the dictionary at once; the attribute table is not cleared.

module tile_quad_dedup_dictionary_unit #(
    parameter int DICT_DEPTH = 256,
    parameter int ATTR_DEPTH = 256
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    tqdd_in_if.sink     item,
    tqdd_out_if.source  result
);

    localparam int CNT_W  = $clog2(DICT_DEPTH + 1);
    localparam int AA_W   = $clog2(ATTR_DEPTH);
    localparam int SLOT_W = tqdd_pkg::TILE_W + 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    localparam logic [2:0] RD_DONE = 3'd4;

    logic [1:0]                     state_reg, state_next;
    logic [CNT_W-1:0]               count_reg, count_next;
    tqdd_pkg::dict_token_t          launch_reg, launch_next;
    logic                           enc_reg, enc_next;
    logic                           res_hit_reg, res_hit_next;
    logic                           res_new_reg, res_new_next;
    logic [tqdd_pkg::IDX_W-1:0]     res_idx_reg, res_idx_next;
    logic [tqdd_pkg::TILE_W-1:0]    tile_reg [4];
    logic [tqdd_pkg::TILE_W-1:0]    tile_next [4];
    logic [2:0]                     rd_cnt_reg, rd_cnt_next;
    logic                           iss_valid_reg, iss_valid_next;
    logic [1:0]                     iss_pos_reg, iss_pos_next;
    logic                           iss_inrange_reg, iss_inrange_next;
    logic [tqdd_pkg::PACK_W-1:0]    packed_reg, packed_next;
    logic                           out_valid_reg, out_valid_next;
    logic [tqdd_pkg::IDX_W-1:0]     out_idx_reg, out_idx_next;
    logic                           out_new_reg, out_new_next;
    logic [tqdd_pkg::PACK_W-1:0]    out_packed_reg, out_packed_next;
    logic                           out_ovf_reg, out_ovf_next;

    tqdd_pkg::dict_token_t          chain_tok [DICT_DEPTH + 1];
    logic                           item_xfer;
    logic                           out_free;
    logic                           attr_done;
    logic [tqdd_pkg::TILE_W-1:0]    cur_tile;
    logic                           attr_wr_en;
    logic                           attr_rd_en;
    logic [tqdd_pkg::ATTR_W-1:0]    attr_rd_data;
    logic [tqdd_pkg::TILE_W-1:0]    m_ne, m_sw, m_se;

    assign item.ready = (state_reg == ST_IDLE);
    assign item_xfer  = item.valid && item.ready;
    assign out_free   = !out_valid_reg || result.ready;
    assign attr_done  = (rd_cnt_reg == RD_DONE) && !iss_valid_reg;

    // Force tiles outside the map to zero
    assign m_ne = item.has_east ? item.tile_ne : '0;
    assign m_sw = item.has_south ? item.tile_sw : '0;
    assign m_se = (item.has_east && item.has_south) ? item.tile_se : '0;

    // Attribute table
    assign attr_wr_en = item_xfer && (item.mode == tqdd_pkg::MODE_LOAD)
                        && (SLOT_W'(item.attr_slot) < SLOT_W'(ATTR_DEPTH));
    assign attr_rd_en = (rd_cnt_reg != RD_DONE);

    always_comb
    begin
        case (rd_cnt_reg[1:0])
            2'd0:    cur_tile = tile_reg[0];
            2'd1:    cur_tile = tile_reg[1];
            2'd2:    cur_tile = tile_reg[2];
            default: cur_tile = tile_reg[3];
        endcase
    end

    tqdd_ram #(
        .WIDTH (tqdd_pkg::ATTR_W),
        .DEPTH (ATTR_DEPTH)
    ) u_attr_ram (
        .clk     (clk),
        .wr_en   (attr_wr_en),
        .wr_addr (item.attr_slot[AA_W-1:0]),
        .wr_data (item.attr_value),
        .rd_en   (attr_rd_en),
        .rd_addr (cur_tile[AA_W-1:0]),
        .rd_data (attr_rd_data)
    );

    // Row of dictionary cells
    assign chain_tok[0] = launch_reg;

    for (genvar g = 0; g < DICT_DEPTH; g++)
    begin : g_cell
        tqdd_cell #(
            .CNT_W    (CNT_W),
            .CELL_IDX (g)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .count   (count_reg),
            .tok_in  (chain_tok[g]),
            .tok_out (chain_tok[g + 1])
        );
    end

    // Sequence control, attribute reads and result assembly
    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        launch_next      = '0;
        enc_next         = enc_reg;
        res_hit_next     = res_hit_reg;
        res_new_next     = res_new_reg;
        res_idx_next     = res_idx_reg;
        tile_next        = tile_reg;
        rd_cnt_next      = rd_cnt_reg;
        iss_valid_next   = 1'b0;
        iss_pos_next     = iss_pos_reg;
        iss_inrange_next = iss_inrange_reg;
        packed_next      = packed_reg;
        out_valid_next   = out_valid_reg && !result.ready;
        out_idx_next     = out_idx_reg;
        out_new_next     = out_new_reg;
        out_packed_next  = out_packed_reg;
        out_ovf_next     = out_ovf_reg;

        // Issue one attribute read per cycle, collect the data in the cycle after
        if (attr_rd_en)
        begin
            iss_valid_next   = 1'b1;
            iss_pos_next     = rd_cnt_reg[1:0];
            iss_inrange_next = SLOT_W'(cur_tile) < SLOT_W'(ATTR_DEPTH);
            rd_cnt_next      = rd_cnt_reg + 3'd1;
        end
        if (iss_valid_reg)
        begin
            packed_next[{iss_pos_reg, 1'b0} +: tqdd_pkg::ATTR_W] =
                iss_inrange_reg ? attr_rd_data : '0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (item_xfer)
                begin
                    enc_next    = (item.mode == tqdd_pkg::MODE_ENCODE);
                    packed_next = '0;
                    if (item.mode == tqdd_pkg::MODE_ENCODE)
                    begin
                        launch_next.valid = 1'b1;
                        launch_next.key   = {m_se, m_sw, m_ne, item.tile_nw};
                        tile_next[0]      = item.tile_nw;
                        tile_next[1]      = m_ne;
                        tile_next[2]      = m_sw;
                        tile_next[3]      = m_se;
                        rd_cnt_next       = '0;
                        state_next        = ST_RUN;
                    end
                    else
                    begin
                        if (item.mode == tqdd_pkg::MODE_CLEAR)
                        begin
                            count_next = '0;
                        end
                        state_next = ST_WAIT;
                    end
                end
            end
            ST_RUN:
            begin
                if (chain_tok[DICT_DEPTH].valid)
                begin
                    res_hit_next = chain_tok[DICT_DEPTH].hit;
                    res_new_next = chain_tok[DICT_DEPTH].fresh;
                    res_idx_next = chain_tok[DICT_DEPTH].idx;
                    state_next   = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (attr_done && out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_idx_next    = (enc_reg && res_hit_reg) ? res_idx_reg : '0;
                    out_new_next    = enc_reg && res_new_reg;
                    out_ovf_next    = enc_reg && !res_hit_reg;
                    out_packed_next = enc_reg ? packed_reg : '0;
                    if (enc_reg && res_new_reg)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            launch_reg     <= '0;
            rd_cnt_reg     <= RD_DONE;
            iss_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            launch_reg     <= launch_next;
            rd_cnt_reg     <= rd_cnt_next;
            iss_valid_reg  <= iss_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        enc_reg         <= enc_next;
        res_hit_reg     <= res_hit_next;
        res_new_reg     <= res_new_next;
        res_idx_reg     <= res_idx_next;
        tile_reg        <= tile_next;
        iss_pos_reg     <= iss_pos_next;
        iss_inrange_reg <= iss_inrange_next;
        packed_reg      <= packed_next;
        out_idx_reg     <= out_idx_next;
        out_new_reg     <= out_new_next;
        out_packed_reg  <= out_packed_next;
        out_ovf_reg     <= out_ovf_next;
    end

    assign result.valid       = out_valid_reg;
    assign result.group_index = out_idx_reg;
    assign result.is_new      = out_new_reg;
    assign result.packed_attr = out_packed_reg;
    assign result.overflow    = out_ovf_reg;

endmodule

`default_nettype wire

// ===== rtl/tqdd_ram.sv =====
`default_nettype none

module tqdd_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 256
) (
    input  wire logic                      clk,
    input  wire logic                      wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]  wr_addr,
    input  wire logic [WIDTH-1:0]          wr_data,
    input  wire logic                      rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]  rd_addr,
    output logic      [WIDTH-1:0]          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tqdd_cell.sv =====
`default_nettype none

module tqdd_cell #(
    parameter int CNT_W    = 9,
    parameter int CELL_IDX = 0
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic [CNT_W-1:0]       count,
    input  wire tqdd_pkg::dict_token_t  tok_in,
    output tqdd_pkg::dict_token_t       tok_out
);

    logic [tqdd_pkg::KEY_W-1:0] key_reg;
    logic [tqdd_pkg::KEY_W-1:0] key_next;
    tqdd_pkg::dict_token_t      tok_reg;
    tqdd_pkg::dict_token_t      tok_next;
    logic                       in_use;
    logic                       is_free;

    assign in_use  = CNT_W'(CELL_IDX) < count;
    assign is_free = CNT_W'(CELL_IDX) == count;

    // Compare against the held key, or claim the first free cell on a miss
    always_comb
    begin
        tok_next = tok_in;
        key_next = key_reg;
        if (tok_in.valid && !tok_in.hit)
        begin
            if (in_use && (key_reg == tok_in.key))
            begin
                tok_next.hit = 1'b1;
                tok_next.idx = tqdd_pkg::IDX_W'(CELL_IDX);
            end
            else if (is_free)
            begin
                key_next       = tok_in.key;
                tok_next.hit   = 1'b1;
                tok_next.fresh = 1'b1;
                tok_next.idx   = tqdd_pkg::IDX_W'(CELL_IDX);
            end
        end
    end

    // Hand the token on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    // Hold the stored key
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire
